// ===== src/upd_pkg.sv =====
// Shared types, character constants and hex helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]                  n;
    res_t [MAX_RESULTS-1:0]      r;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h61 + {4'h0, HEX_LETTER_BASE};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h41 + {4'h0, HEX_LETTER_BASE};
      end
      hex_val = d[3:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/url_percent_decoder.sv =====
// Top level of the URL percent decoder: escape state, config register, result queue.
`default_nettype none
// URL percent decoder. Encoded bytes enter on in_byte/is_last, one transaction
// per cycle; decoded bytes leave on out_byte/out_last, at most one per cycle,
// with each transaction's results registered into the result queue. "%hh"
// (hex digits of either case) collapses to one byte; a broken or truncated
// escape passes through as-is, and with plus_is_space set a '+' outside an
// escape becomes a space. Rate: one input byte per cycle as long as each byte
// yields at most one result and out_ready stays high. A broken escape yields
// one to three results, and the output port (one result per cycle) then sets
// the pace: in_ready follows the occupancy of the four-entry result queue and
// is high while at most one result is pending. Write plus_is_space through
// cfg_we/cfg_wdata only while the block is idle.
module url_percent_decoder
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  // encoded input stream
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       is_last,
  // decoded output stream
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic       plus_is_space;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  group_t     grp;
  res_t       head;
  logic       in_accept;

  assign in_accept = in_valid && in_ready;

  // escape decode for the byte on the input port
  upd_decode u_decode (
    .in_byte       (in_byte),
    .is_last       (is_last),
    .plus_is_space (plus_is_space),
    .phase         (phase),
    .held          (held),
    .grp           (grp),
    .phase_next    (phase_next),
    .held_next     (held_next)
  );

  // results wait here until the consumer takes them
  upd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (in_accept),
    .wr_grp     (grp),
    .space_ok   (in_ready),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head       (head)
  );

  assign out_byte = head.data;
  assign out_last = head.last;

  // escape state only advances on an input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      held          <= 8'h00;
      plus_is_space <= 1'b0;
    end else begin
      if (cfg_we) begin
        plus_is_space <= cfg_wdata;
      end
      if (in_accept) begin
        phase <= phase_next;
        held  <= held_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/upd_decode.sv =====
// Escape decode: one encoded byte plus escape state in, up to three results out.
`default_nettype none
module upd_decode
  import upd_pkg::*;
(
  input  wire logic [7:0] in_byte,
  input  wire logic       is_last,
  input  wire logic       plus_is_space,
  input  wire phase_t     phase,
  input  wire logic [7:0] held,
  output group_t          grp,
  output phase_t          phase_next,
  output logic [7:0]      held_next
);

  logic       pct_hold;
  logic [7:0] mapped;

  always_comb begin
    // plain-byte path: a non-final percent opens an escape
    pct_hold = (in_byte == PCT_CHAR) && !is_last;
    mapped   = (plus_is_space && in_byte == PLUS_CHAR) ? SPACE_CHAR : in_byte;

    grp        = '0;
    phase_next = PH_IDLE;
    held_next  = held;

    case (phase)
      PH_PCT: begin
        if (is_hex(in_byte) && !is_last) begin
          phase_next = PH_DIGIT;
          held_next  = in_byte;
        end else begin
          grp.r[0] = '{data: PCT_CHAR, last: 1'b0};
          if (pct_hold) begin
            grp.n      = 2'd1;
            phase_next = PH_PCT;
          end else begin
            grp.r[1] = '{data: mapped, last: is_last};
            grp.n    = 2'd2;
          end
        end
      end
      PH_DIGIT: begin
        held_next = 8'h00;
        if (is_hex(in_byte)) begin
          grp.r[0] = '{data: {hex_val(held), hex_val(in_byte)}, last: is_last};
          grp.n    = 2'd1;
        end else begin
          // broken escape: flush percent and held digit first
          grp.r[0] = '{data: PCT_CHAR, last: 1'b0};
          grp.r[1] = '{data: held, last: 1'b0};
          if (pct_hold) begin
            grp.n      = 2'd2;
            phase_next = PH_PCT;
          end else begin
            grp.r[2] = '{data: mapped, last: is_last};
            grp.n    = 2'd3;
          end
        end
      end
      default: begin
        if (pct_hold) begin
          phase_next = PH_PCT;
        end else begin
          grp.r[0] = '{data: mapped, last: is_last};
          grp.n    = 2'd1;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/upd_out_queue.sv =====
// Result queue: takes a group of up to three results, drains one per cycle while the consumer is ready.
`default_nettype none
module upd_out_queue
  import upd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire group_t wr_grp,
  output logic        space_ok,
  output logic        head_valid,
  input  wire logic   head_ready,
  output res_t        head
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] base;
  logic [1:0]       wr_n;
  logic             pop;
  res_t             entry      [QUEUE_DEPTH];
  res_t             entry_next [QUEUE_DEPTH];

  assign head_valid = (count != '0);
  assign head       = entry[0];
  // room for a full group regardless of this cycle's drain
  assign space_ok   = (count <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

  always_comb begin
    pop  = head_valid && head_ready;
    base = count - CNT_W'(pop);
    wr_n = wr_en ? wr_grp.n : 2'd0;

    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      entry_next[i] = pop ? entry[i+1] : entry[i];
    end
    entry_next[QUEUE_DEPTH-1] = entry[QUEUE_DEPTH-1];

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
        if (CNT_W'(k) < CNT_W'(wr_n) && CNT_W'(i) == base + CNT_W'(k)) begin
          entry_next[i] = wr_grp.r[k];
        end
      end
    end

    count_next = base + CNT_W'(wr_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entry[i] <= entry_next[i];
    end
  end

endmodule
`default_nettype wire

// ===== bench/upd_checker.sv =====
// Checker for the URL percent decoder: predicts decoded bytes and compares them.
module upd_checker
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       is_last,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_last,
  output int              fail_count,
  output int              pending,
  output int              results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t     esc_state;
  logic [7:0] first_digit;
  logic       query_mode;
  res_t       decoded_q[$];
  int         err_total;
  int         seen_total;

  // {is_hex, nibble}
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      return {1'b1, c[3:0] - 4'd1 + HEX_LETTER_BASE};
    return 5'd0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    err_total++;
  endtask

  task automatic push_result(input logic [7:0] b, input logic l);
    res_t r;
    r.data = b;
    r.last = l;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  // byte seen with no escape pending
  task automatic take_plain(input logic [7:0] b, input logic l);
    if (b == PCT_CHAR && !l) begin
      esc_state = PH_PCT;
    end else if (b == PLUS_CHAR && query_mode) begin
      push_result(SPACE_CHAR, l);
    end else begin
      push_result(b, l);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic l);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = decode_hex(b);
    case (esc_state)
      PH_PCT: begin
        esc_state = PH_IDLE;
        if (lo[4] && !l) begin
          first_digit = b;
          esc_state = PH_DIGIT;
        end else begin
          push_result(PCT_CHAR, 1'b0);
          take_plain(b, l);
        end
      end
      PH_DIGIT: begin
        esc_state = PH_IDLE;
        if (lo[4]) begin
          hi = decode_hex(first_digit);
          push_result({hi[3:0], lo[3:0]}, l);
        end else begin
          push_result(PCT_CHAR, 1'b0);
          push_result(first_digit, 1'b0);
          take_plain(b, l);
        end
        first_digit = 8'h00;
      end
      default: begin
        esc_state = PH_IDLE;
        take_plain(b, l);
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      esc_state = PH_IDLE;
      first_digit = 8'h00;
      query_mode = 1'b0;
      decoded_q.delete();
      err_total = 0;
      seen_total = 0;
    end else begin
      if (cfg_we) query_mode = cfg_wdata;
      if (out_valid && out_ready) begin
        seen_total++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                    out_byte, out_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, predicted %02h", out_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, predicted %0b (byte %02h)",
                                      out_last, want.last, want.data));
        end
      end
      if (in_valid && in_ready) predict_byte(in_byte, is_last);
    end
    fail_count   <= err_total;
    pending      <= decoded_q.size();
    results_seen <= seen_total;
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the URL percent decoder: stimulus, backpressure, watchdog, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import upd_pkg::*;

  // Longest run of cycles with no transaction on any port before giving up.
  // The deliberate output hold-off is well below this.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       is_last   = 1'b0;
  logic       out_ready = 1'b0;
  wire logic       in_ready;
  wire logic       out_valid;
  wire logic [7:0] out_byte;
  wire logic       out_last;

  int fail_count;
  int pending;
  int results_seen;

  // Shared between the stimulus and the receiver process.
  bit idle_enable  = 1'b1;
  bit hold_request = 1'b0;

  int bytes_sent  = 0;
  int strings_ok  = 0;
  int mode_writes = 0;
  int quiet_run   = 0;

  // Directed strings, {is_last, byte}. Plain mode first:
  //   "%4a" lowercase escape, "%FF" and "%00" value extremes, plain 00 and FF,
  //   '+' left alone, "%G" broken after the percent, "%%1f" where the second
  //   percent restarts the escape, and a percent as the final byte.
  logic [8:0] plain_seq [19] = '{
    {1'b0, 8'h25}, {1'b0, 8'h34}, {1'b0, 8'h61},
    {1'b0, 8'h25}, {1'b0, 8'h46}, {1'b0, 8'h46},
    {1'b0, 8'h25}, {1'b0, 8'h30}, {1'b0, 8'h30},
    {1'b0, 8'h00}, {1'b1, 8'hFF}, {1'b0, 8'h2B},
    {1'b0, 8'h25}, {1'b0, 8'h47},
    {1'b0, 8'h25}, {1'b0, 8'h25}, {1'b0, 8'h31}, {1'b0, 8'h66},
    {1'b1, 8'h25}
  };
  // Query mode: '+' becomes space, "%2B" decodes to '+' and is not remapped,
  // "%7+" breaks after a digit and flushes three bytes ending the string,
  // "%A" is cut off by the end of the string.
  logic [8:0] query_seq [9] = '{
    {1'b0, 8'h2B},
    {1'b0, 8'h25}, {1'b0, 8'h32}, {1'b1, 8'h42},
    {1'b0, 8'h25}, {1'b0, 8'h37}, {1'b1, 8'h2B},
    {1'b0, 8'h25}, {1'b1, 8'h41}
  };

  url_percent_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  upd_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  // Watchdog: any accepted transaction or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_run <= 0;
    end else begin
      quiet_run <= quiet_run + 1;
      if (quiet_run >= STALL_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: ready bursts, random stall bursts, and one long hold-off on request.
  // Each branch drives out_ready once and then waits before choosing again.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Random hex digit, digits and both letter cases alike.
  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'h30 + r[7:0];
    if (r < 16) return 8'h61 + r[7:0] - 8'd10;
    return 8'h41 + r[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
    return b;
  endfunction

  function automatic logic coin(input int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // Offer one byte, with an optional gap first; valid stays up across
  // back-to-back transactions. Returns at the edge that accepted it.
  task automatic send_byte(input logic [7:0] b, input logic l);
    if (idle_enable && coin(8)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    is_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (l) strings_ok++;
  endtask

  // Drain everything, let the pipeline settle, then write the mode register.
  task automatic set_query_mode(input logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_writes++;
  endtask

  // Random traffic, mostly well-formed escapes and plain text, with broken
  // and truncated escapes mixed in. Optionally requests the long hold-off
  // partway through. Ends on a final byte so no escape is left pending.
  task automatic run_phase(input int n_items, input int hold_at);
    int k;
    int kind;
    k = 0;
    while (k < n_items) begin
      if (k >= hold_at && hold_at >= 0 && !hold_request && k < hold_at + 4)
        hold_request = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_byte(PCT_CHAR, 1'b0);
        send_byte(pick_hex(), 1'b0);
        send_byte(pick_hex(), coin(6));
        k += 3;
      end else if (kind < 45) begin
        send_byte(PLUS_CHAR, coin(6));
        k += 1;
      end else if (kind < 55) begin
        // broken escape, after the percent or after one digit
        send_byte(PCT_CHAR, 1'b0);
        if (coin(2)) begin
          send_byte(pick_hex(), 1'b0);
          k += 1;
        end
        send_byte(coin(4) ? PLUS_CHAR : pick_non_hex(), coin(6));
        k += 2;
      end else if (kind < 60) begin
        // escape cut off by the end of the string
        if (coin(2)) begin
          send_byte(PCT_CHAR, 1'b1);
          k += 1;
        end else begin
          send_byte(PCT_CHAR, 1'b0);
          send_byte(pick_hex(), 1'b1);
          k += 2;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)), coin(8));
        k += 1;
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, plain mode straight out of reset, then query mode.
    foreach (plain_seq[i]) send_byte(plain_seq[i][7:0], plain_seq[i][8]);
    set_query_mode(1'b1);
    foreach (query_seq[i]) send_byte(query_seq[i][7:0], query_seq[i][8]);

    // Random part across both modes; the second phase fills the block
    // behind a long receiver hold-off.
    set_query_mode(1'b0);
    run_phase(100, -1);
    set_query_mode(1'b1);
    run_phase(100, 30);
    set_query_mode(coin(2));
    run_phase(100, -1);

    // Last stretch at full rate on both sides.
    set_query_mode(1'b0);
    idle_enable = 1'b0;
    run_phase(100, -1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Run covered %0d encoded bytes in %0d strings, %0d decoded bytes checked,",
             bytes_sent, strings_ok, results_seen);
    $display("%0d mode register writes, random gaps on both sides, one %0d-cycle hold-off.",
             mode_writes, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
